// ----- sv/ils_pkg.sv -----
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;
  localparam int ACT_W    = 3;
  localparam int ECNT_W   = 7;
  localparam int STAT_W   = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GET      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SET      = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd6;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  typedef struct packed {
    logic exec;
  } ils_cmd_t;

endpackage

// ----- sv/ils_ctrl.sv -----
module ils_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ils_pkg::ils_cmd_t cmd
);
  import ils_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_tready  = (state_r == S_IDLE) || out_tready;
  assign out_tvalid = (state_r == S_HOLD);
  assign cmd.exec   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.exec) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_tready && !cmd.exec) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/ils_datapath.sv -----
module ils_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ils_pkg::ils_cmd_t               cmd,
  input  logic [ils_pkg::ACT_W-1:0]       action,
  input  logic [ils_pkg::POS_W-1:0]       position,
  input  logic signed [ils_pkg::DATA_W-1:0] value,
  output logic signed [ils_pkg::DATA_W-1:0] read_data,
  output logic [ils_pkg::ECNT_W-1:0]      entry_count,
  output logic [ils_pkg::STAT_W-1:0]      status
);
  import ils_pkg::*;

  logic [DATA_W-1:0] cells_r   [CAPACITY];
  logic [DATA_W-1:0] cells_nxt [CAPACITY];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [DATA_W-1:0] rd_r;
  logic [DATA_W-1:0] rd_nxt;
  logic [STAT_W-1:0] stat_r;
  logic [STAT_W-1:0] stat_nxt;

  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              is_empty;
  logic              is_full;
  logic              in_range;
  logic [DATA_W-1:0] cell_at_pos;

  logic do_append;
  logic do_insert;
  logic do_first;
  logic do_remove;
  logic do_set;

  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(count_r);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r >= CNT_W'(CAPACITY));
  assign in_range = (pos_ext < cnt_ext);

  always_comb begin
    cell_at_pos = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (CMP_W'(k) == pos_ext) cell_at_pos = cells_r[k];
    end
  end

  always_comb begin
    count_nxt = count_r;
    rd_nxt    = '0;
    stat_nxt  = STAT_DONE;
    do_append = 1'b0;
    do_insert = 1'b0;
    do_first  = 1'b0;
    do_remove = 1'b0;
    do_set    = 1'b0;
    case (action)
      ACT_APPEND: begin
        if (is_full) begin
          stat_nxt = STAT_FULL;
        end else begin
          do_append = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_INSERT: begin
        if (is_empty) begin
          do_first  = 1'b1;
          count_nxt = CNT_W'(1);
        end else if (is_full) begin
          stat_nxt = STAT_FULL;
        end else if (!in_range) begin
          stat_nxt = STAT_RANGE;
        end else begin
          do_insert = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (is_empty) begin
          stat_nxt = STAT_EMPTY;
        end else if (!in_range) begin
          stat_nxt = STAT_RANGE;
        end else begin
          do_remove = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_POP: begin
        if (is_empty) begin
          stat_nxt = STAT_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_GET: begin
        if (is_empty) begin
          stat_nxt = STAT_EMPTY;
        end else if (!in_range) begin
          stat_nxt = STAT_RANGE;
        end else begin
          rd_nxt = cell_at_pos;
        end
      end
      ACT_SET: begin
        if (is_empty) begin
          stat_nxt = STAT_EMPTY;
        end else if (!in_range) begin
          stat_nxt = STAT_RANGE;
        end else begin
          do_set = 1'b1;
        end
      end
      ACT_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        stat_nxt = STAT_RANGE;
      end
    endcase
  end

  // next row of cells: shift in parallel for insert and remove, write value for append, first insert and set
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cells_nxt[k] = cells_r[k];
      if (do_append && (CNT_W'(k) == count_r)) cells_nxt[k] = value;
      if (do_first && (k == 0)) cells_nxt[k] = value;
      if (do_set && (CMP_W'(k) == pos_ext)) cells_nxt[k] = value;
      if (do_insert) begin
        if (CMP_W'(k) == pos_ext) begin
          cells_nxt[k] = value;
        end else if ((k > 0) && (CMP_W'(k) > pos_ext)) begin
          cells_nxt[k] = cells_r[(k > 0) ? k - 1 : 0];
        end
      end
      if (do_remove && (k < CAPACITY - 1) && (CMP_W'(k) >= pos_ext)) begin
        cells_nxt[k] = cells_r[(k < CAPACITY - 1) ? k + 1 : k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int k = 0; k < CAPACITY; k++) cells_r[k] <= cells_nxt[k];
      rd_r   <= rd_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign read_data   = rd_r;
  assign entry_count = ECNT_W'(count_r);
  assign status      = stat_r;

endmodule

// ----- sv/indexed_list_store_core.sv -----
// Indexed list store: an ordered list of up to 64 signed 32-bit entries.
// Input stream in_*: one request per transfer carrying action, position and
// value (append, insert, remove at index, remove last, get, set, clear).
// Output stream out_*: exactly one result per request, in request order,
// with the read data, the entry count after the action and a status code
// (done, index out of range, list full, list empty).
// Every action completes in the cycle it is accepted: the entries sit in a
// row of registers that shifts up or down in parallel for insert and remove.
// The result appears in the cycle after acceptance and stays in the output
// register until taken; one request per cycle is sustained while the
// receiver takes results each cycle.
// When the receiver stalls, a single result is held and in_tready drops
// until that result is taken; no request is lost or repeated.
// Reset empties the list (count zero); entry contents are left as they were
// and are never read until written again.
module indexed_list_store_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ils_pkg::IN_TDATA_W-1:0]   in_tdata,  // action, position, value, zero pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ils_pkg::OUT_TDATA_W-1:0]  out_tdata  // read_data, entry_count, status, zero pad
);
  import ils_pkg::*;

  ils_cmd_t                 cmd;
  logic signed [DATA_W-1:0] read_data;
  logic [ECNT_W-1:0]        entry_count;
  logic [STAT_W-1:0]        status;

  ils_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ils_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .action      (in_tdata[2:0]),
    .position    (in_tdata[8:3]),
    .value       (in_tdata[40:9]),
    .read_data   (read_data),
    .entry_count (entry_count),
    .status      (status)
  );

  assign out_tdata = {7'd0, status, entry_count, read_data};

endmodule
